// ===== hw/rtl/hsps_pkg.sv =====
// hsps_pkg: shared types, sizes and comb tables for the harmonic sieve pitch search
// used by hsps_cell and harmonic_sieve_pitch_search; depends on nothing else
`timescale 1ns / 1ps

package hsps_pkg;

    // band store size and derived widths
    localparam int MAX_BANDS = 256;
    localparam int ADDR_W    = $clog2(MAX_BANDS);
    localparam int CNT_W     = $clog2(MAX_BANDS + 1);

    // comb shape
    localparam int COMB_TAPS = 11;
    localparam int TAP_W     = $clog2(COMB_TAPS);

    // field widths
    localparam int BAND_W   = 8;
    localparam int POWER_W  = 32;
    localparam int WEIGHT_W = 16;
    localparam int PROD_W   = POWER_W + WEIGHT_W;
    localparam int SCORE_W  = 51;

    // root plus offset, wide enough to compare against the band count
    localparam int CMP_W = ((CNT_W > BAND_W + 1) ? CNT_W : BAND_W + 1) + 1;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_BAND = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BAND = CFG_IDX_W'(1);

    typedef struct packed {
        logic [POWER_W-1:0] band_power;
        logic               frame_end;
    } hsps_band_t;

    typedef struct packed {
        logic [BAND_W-1:0]  best_band;
        logic [SCORE_W-1:0] best_score;
    } hsps_pitch_t;

    // write bundle shared by every cell copy of the band store
    typedef struct packed {
        logic               en;
        logic [ADDR_W-1:0]  addr;
        logic [POWER_W-1:0] data;
    } hsps_wr_t;

    // partial score traveling down the chain
    typedef struct packed {
        logic               last;
        logic [BAND_W-1:0]  root;
        logic [SCORE_W-1:0] psum;
    } hsps_token_t;

    // harmonic band offsets
    function automatic logic [BAND_W-1:0] comb_offset(input logic [TAP_W-1:0] tap);
        logic [BAND_W-1:0] off;
        case (tap)
            TAP_W'(0):  off = BAND_W'(0);
            TAP_W'(1):  off = BAND_W'(24);
            TAP_W'(2):  off = BAND_W'(38);
            TAP_W'(3):  off = BAND_W'(48);
            TAP_W'(4):  off = BAND_W'(56);
            TAP_W'(5):  off = BAND_W'(62);
            TAP_W'(6):  off = BAND_W'(67);
            TAP_W'(7):  off = BAND_W'(72);
            TAP_W'(8):  off = BAND_W'(76);
            TAP_W'(9):  off = BAND_W'(80);
            TAP_W'(10): off = BAND_W'(83);
            default:    off = '0;
        endcase
        return off;
    endfunction

    // weights 1.0 down to 0.6, 1.0 = 32768
    function automatic logic [WEIGHT_W-1:0] comb_weight(input logic [TAP_W-1:0] tap);
        logic [WEIGHT_W-1:0] w;
        case (tap)
            TAP_W'(0):  w = WEIGHT_W'(32768);
            TAP_W'(1):  w = WEIGHT_W'(31457);
            TAP_W'(2):  w = WEIGHT_W'(30147);
            TAP_W'(3):  w = WEIGHT_W'(28836);
            TAP_W'(4):  w = WEIGHT_W'(27525);
            TAP_W'(5):  w = WEIGHT_W'(26214);
            TAP_W'(6):  w = WEIGHT_W'(24904);
            TAP_W'(7):  w = WEIGHT_W'(23593);
            TAP_W'(8):  w = WEIGHT_W'(22282);
            TAP_W'(9):  w = WEIGHT_W'(20972);
            TAP_W'(10): w = WEIGHT_W'(19661);
            default:    w = '0;
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/hsps_ram.sv =====
// hsps_ram: generic single write port ram with registered read
// no package dependency
`timescale 1ns / 1ps

module hsps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/hsps_cell.sv =====
// hsps_cell: one comb tap; own copy of the band store, weight multiply, partial sum add
// depends on hsps_pkg and hsps_ram
`timescale 1ns / 1ps

module hsps_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [hsps_pkg::TAP_W-1:0] tap,
    input  logic [hsps_pkg::CNT_W-1:0] bands_loaded,
    input  hsps_pkg::hsps_wr_t         wr,
    input  logic                       tok_valid,
    input  hsps_pkg::hsps_token_t      tok,
    output logic                       out_valid,
    output hsps_pkg::hsps_token_t      out_tok
);

    import hsps_pkg::*;

    logic [CMP_W-1:0]    idx;
    logic                hit;
    logic [POWER_W-1:0]  rd_data;
    logic [WEIGHT_W-1:0] weight;

    logic                s1_valid_reg, s1_valid_next;
    hsps_token_t         s1_tok_reg, s1_tok_next;
    logic                s1_hit_reg, s1_hit_next;
    logic                s2_valid_reg, s2_valid_next;
    hsps_token_t         s2_tok_reg, s2_tok_next;
    logic [PROD_W-1:0]   s2_prod_reg, s2_prod_next;
    logic                out_valid_reg, out_valid_next;
    hsps_token_t         out_tok_reg, out_tok_next;

    // band index this tap looks at; past the loaded bands reads as zero
    assign idx    = CMP_W'(tok.root) + CMP_W'(comb_offset(tap));
    assign hit    = idx < CMP_W'(bands_loaded);
    assign weight = comb_weight(tap);

    hsps_ram #(
        .WIDTH(POWER_W),
        .DEPTH(MAX_BANDS)
    ) u_store (
        .clk    (clk),
        .wr_en  (wr.en),
        .wr_addr(wr.addr),
        .wr_data(wr.data),
        .rd_addr(idx[ADDR_W-1:0]),
        .rd_data(rd_data)
    );

    always_comb
    begin
        s1_valid_next  = tok_valid;
        s1_tok_next    = tok;
        s1_hit_next    = hit;
        s2_valid_next  = s1_valid_reg;
        s2_tok_next    = s1_tok_reg;
        s2_prod_next   = s1_hit_reg ? PROD_W'(rd_data) * PROD_W'(weight) : '0;
        out_valid_next = s2_valid_reg;
        out_tok_next   = s2_tok_reg;
        out_tok_next.psum = s2_tok_reg.psum + SCORE_W'(s2_prod_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_tok_reg  <= s1_tok_next;
        s1_hit_reg  <= s1_hit_next;
        s2_tok_reg  <= s2_tok_next;
        s2_prod_reg <= s2_prod_next;
        out_tok_reg <= out_tok_next;
    end

    assign out_valid = out_valid_reg;
    assign out_tok   = out_tok_reg;

endmodule

// ===== hw/rtl/harmonic_sieve_pitch_search.sv =====
// harmonic_sieve_pitch_search: top level, frame loader, root sequencer, best tracker
// depends on hsps_pkg, hsps_cell and hsps_ram
`timescale 1ns / 1ps

// Bands of a frame are taken one per cycle while the block is loading and are written
// into every cell's copy of the band store; bands past the store size are dropped.
// The transfer carrying frame_end starts the search: root bands from min_band up to
// max_band - 1 enter the chain of eleven tap cells one per cycle, each cell adding its
// weighted harmonic to the partial score through its read, multiply and add registers,
// so a frame goes through loading its bands, the search, and then the hand-over of the
// result to the output register. An empty range (max_band at or below
// min_band) skips the chain and gives band 0 with score 0. Input is stalled from the
// frame-end transfer until the result sits in the output register; the output register
// lets the next frame load while the previous result waits. No clearing pass is needed:
// the store is only read below the count of bands loaded in the current frame.
// Configuration is always ready and must only be written while the block is idle.

module harmonic_sieve_pitch_search (
    input  logic                           clk,
    input  logic                           rst_n,
    // band input channel
    input  logic                           band_valid,
    output logic                           band_stall,
    input  hsps_pkg::hsps_band_t           band_item,
    // result channel
    output logic                           pitch_valid,
    input  logic                           pitch_stall,
    output hsps_pkg::hsps_pitch_t          pitch_item,
    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hsps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hsps_pkg::BAND_W-1:0]    cfg_data
);

    import hsps_pkg::*;

    // one-hot sequencer states
    typedef enum logic [3:0] {
        S_LOAD  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_HOLD  = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   bands_loaded_reg, bands_loaded_next;
    logic [BAND_W-1:0]  min_band_reg, min_band_next;
    logic [BAND_W-1:0]  max_band_reg, max_band_next;
    logic [BAND_W-1:0]  root_reg, root_next;
    logic [SCORE_W-1:0] best_so_far_reg, best_so_far_next;
    logic [BAND_W-1:0]  best_index_reg, best_index_next;
    logic               pitch_valid_reg, pitch_valid_next;
    hsps_pitch_t        pitch_item_reg, pitch_item_next;

    logic               band_accept;
    logic               range_empty;
    logic [BAND_W-1:0]  range_lo;
    hsps_wr_t           wr;

    // chain links: index 0 is the issue point, index COMB_TAPS the chain output
    logic               link_valid [COMB_TAPS+1];
    hsps_token_t        link_tok   [COMB_TAPS+1];

    assign band_stall  = (state_reg != S_LOAD);
    assign band_accept = band_valid && !band_stall;
    assign cfg_ready   = 1'b1;

    // a reversed range collapses to an empty one
    assign range_empty = (max_band_reg <= min_band_reg);
    assign range_lo    = range_empty ? max_band_reg : min_band_reg;

    // every transfer while room remains goes into all store copies
    assign wr.en   = band_accept && (bands_loaded_reg != CNT_W'(MAX_BANDS));
    assign wr.addr = bands_loaded_reg[ADDR_W-1:0];
    assign wr.data = band_item.band_power;

    // issue one root per cycle while scanning
    assign link_valid[0]    = (state_reg == S_SCAN);
    assign link_tok[0].root = root_reg;
    assign link_tok[0].last = (root_reg == max_band_reg - BAND_W'(1));
    assign link_tok[0].psum = '0;

    for (genvar t = 0; t < COMB_TAPS; t++)
    begin : g_cell
        hsps_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .tap         (TAP_W'(t)),
            .bands_loaded(bands_loaded_reg),
            .wr          (wr),
            .tok_valid   (link_valid[t]),
            .tok         (link_tok[t]),
            .out_valid   (link_valid[t+1]),
            .out_tok     (link_tok[t+1])
        );
    end

    always_comb
    begin
        state_next        = state_reg;
        bands_loaded_next = bands_loaded_reg;
        min_band_next     = min_band_reg;
        max_band_next     = max_band_reg;
        root_next         = root_reg;
        best_so_far_next  = best_so_far_reg;
        best_index_next   = best_index_reg;
        pitch_valid_next  = pitch_valid_reg;
        pitch_item_next   = pitch_item_reg;

        // configuration writes, unknown indexes ignored
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MIN_BAND: min_band_next = cfg_data;
                CFG_MAX_BAND: max_band_next = cfg_data;
                default:      ;
            endcase
        end

        // result leaves on its transfer
        if (pitch_valid_reg && !pitch_stall)
        begin
            pitch_valid_next = 1'b0;
        end

        // first strictly larger score wins, so ties keep the lower root
        if (link_valid[COMB_TAPS] && (link_tok[COMB_TAPS].psum > best_so_far_reg))
        begin
            best_so_far_next = link_tok[COMB_TAPS].psum;
            best_index_next  = link_tok[COMB_TAPS].root;
        end

        case (state_reg)
            S_LOAD:
            begin
                if (band_accept)
                begin
                    if (wr.en)
                    begin
                        bands_loaded_next = bands_loaded_reg + CNT_W'(1);
                    end
                    if (band_item.frame_end)
                    begin
                        best_so_far_next = '0;
                        best_index_next  = '0;
                        root_next        = range_lo;
                        state_next       = range_empty ? S_HOLD : S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                root_next = root_reg + BAND_W'(1);
                if (link_tok[0].last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (link_valid[COMB_TAPS] && link_tok[COMB_TAPS].last)
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                // wait for the output register, then start the next frame
                if (!pitch_valid_reg || !pitch_stall)
                begin
                    pitch_valid_next           = 1'b1;
                    pitch_item_next.best_band  = best_index_reg;
                    pitch_item_next.best_score = best_so_far_reg;
                    bands_loaded_next          = '0;
                    state_next                 = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_LOAD;
            bands_loaded_reg <= '0;
            min_band_reg     <= BAND_W'(0);
            max_band_reg     <= BAND_W'(172);
            root_reg         <= '0;
            best_so_far_reg  <= '0;
            best_index_reg   <= '0;
            pitch_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            bands_loaded_reg <= bands_loaded_next;
            min_band_reg     <= min_band_next;
            max_band_reg     <= max_band_next;
            root_reg         <= root_next;
            best_so_far_reg  <= best_so_far_next;
            best_index_reg   <= best_index_next;
            pitch_valid_reg  <= pitch_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pitch_item_reg <= pitch_item_next;
    end

    assign pitch_valid = pitch_valid_reg;
    assign pitch_item  = pitch_item_reg;

    // scores only come out of the chain during a search
    a_chain_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        link_valid[COMB_TAPS] |-> (state_reg == S_SCAN || state_reg == S_DRAIN))
        else $error("chain output outside a search");

    // nothing left in flight once the result is being handed over
    a_chain_empty_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HOLD) |-> !link_valid[COMB_TAPS] && !link_valid[0])
        else $error("chain busy while holding a result");

    // a zero score always reports band zero
    a_zero_score_band: assert property (@(posedge clk) disable iff (!rst_n)
        (pitch_valid && (pitch_item.best_score == '0)) |-> (pitch_item.best_band == '0))
        else $error("nonzero band with zero score");

    // the band count never passes the store size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bands_loaded_reg <= CNT_W'(MAX_BANDS))
        else $error("band count overflow");

endmodule

// ===== tb/hsps_pitch_checker.sv =====
`timescale 1ns / 1ps
// hsps_pitch_checker: watches the band, result and configuration channels of the pitch
// search, predicts the best root band of every frame and compares; depends on hsps_pkg

module hsps_pitch_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           band_valid,
    input  logic                           band_stall,
    input  hsps_pkg::hsps_band_t           band_item,
    input  logic                           pitch_valid,
    input  logic                           pitch_stall,
    input  hsps_pkg::hsps_pitch_t          pitch_item,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [hsps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hsps_pkg::BAND_W-1:0]    cfg_data,
    output int                             mismatches,
    output int                             pending
);
    import hsps_pkg::*;

    localparam logic [BAND_W-1:0] RESET_MAX_BAND = BAND_W'(172);

    int unsigned         harm_offset [COMB_TAPS];
    logic [WEIGHT_W-1:0] harm_gain   [COMB_TAPS];

    logic [POWER_W-1:0]  frame_bands [MAX_BANDS];
    int                  frame_len;
    logic [BAND_W-1:0]   search_lo;
    logic [BAND_W-1:0]   search_hi;
    hsps_pitch_t         expected_pitches [$];
    hsps_pitch_t         seen;
    hsps_pitch_t         want;
    int                  fail_count;

    initial
    begin
        harm_offset = '{0, 24, 38, 48, 56, 62, 67, 72, 76, 80, 83};
        harm_gain   = '{16'd32768, 16'd31457, 16'd30147, 16'd28836, 16'd27525, 16'd26214,
                        16'd24904, 16'd23593, 16'd22282, 16'd20972, 16'd19661};
    end

    // first root with the strictly highest comb score over the stored frame
    function automatic hsps_pitch_t sieve_best_pitch();
        hsps_pitch_t        best;
        logic [SCORE_W-1:0] acc;
        int                 lo;
        int                 hi;
        int                 root;
        int                 tap;
        int                 idx;
        best = '0;
        lo   = int'(search_lo);
        hi   = int'(search_hi);
        if (hi < lo)
            lo = hi;
        for (root = lo; root < hi; root++)
        begin
            acc = '0;
            for (tap = 0; tap < COMB_TAPS; tap++)
            begin
                idx = root + int'(harm_offset[tap]);
                // taps past the loaded bands read as zero
                if (idx < frame_len)
                    acc += SCORE_W'(harm_gain[tap]) * SCORE_W'(frame_bands[idx]);
            end
            if (acc > best.best_score)
            begin
                best.best_score = acc;
                best.best_band  = BAND_W'(root);
            end
        end
        return best;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_len  = 0;
            search_lo  = '0;
            search_hi  = RESET_MAX_BAND;
            fail_count = 0;
            expected_pitches.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_MIN_BAND)
                    search_lo = cfg_data;
                else if (cfg_index == CFG_MAX_BAND)
                    search_hi = cfg_data;
            end

            if (band_valid && !band_stall)
            begin
                // bands beyond the store size are dropped, frame end included
                if (frame_len < MAX_BANDS)
                begin
                    frame_bands[frame_len] = band_item.band_power;
                    frame_len++;
                end
                if (band_item.frame_end)
                begin
                    expected_pitches.push_back(sieve_best_pitch());
                    frame_len = 0;
                end
            end

            if (pitch_valid && !pitch_stall)
            begin
                seen = pitch_item;
                if (expected_pitches.size() == 0)
                begin
                    $error("unexpected result transfer: best_band %0d best_score %0d",
                           seen.best_band, seen.best_score);
                    fail_count++;
                end
                else
                begin
                    want = expected_pitches.pop_front();
                    if (seen.best_band !== want.best_band)
                    begin
                        $error("best_band expected %0d actual %0d",
                               want.best_band, seen.best_band);
                        fail_count++;
                    end
                    if (seen.best_score !== want.best_score)
                    begin
                        $error("best_score expected %0d actual %0d",
                               want.best_score, seen.best_score);
                        fail_count++;
                    end
                end
            end
        end
        mismatches <= fail_count;
        pending    <= expected_pitches.size();
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// testbench: top of the pitch search bench; drives frames, range settings and result stalls
// depends on hsps_pkg, harmonic_sieve_pitch_search and hsps_pitch_checker

module testbench;
    import hsps_pkg::*;

    localparam int ITEM_TARGET   = 1400;
    localparam int FRAME_TARGET  = 20;
    localparam int IDLE_PCT      = 38;
    localparam int HOLD_CYCLES   = 1500;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES  = 50;
    localparam int LONG_FRAME    = 264;

    // indexes the block has no register for; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = CFG_IDX_W'(3);

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 band_valid  = 1'b0;
    logic                 band_stall;
    hsps_band_t           band_item   = '0;
    logic                 pitch_valid;
    logic                 pitch_stall = 1'b0;
    hsps_pitch_t          pitch_item;
    logic                 cfg_valid   = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [BAND_W-1:0]    cfg_data    = '0;

    int mismatches;
    int pending;
    int items_sent  = 0;
    int frames_sent = 0;

    // calm: neither side idles; hold_req: ask the receiver for one long hold-off
    bit calm     = 1'b0;
    bit hold_req = 1'b0;

    harmonic_sieve_pitch_search dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .band_valid  (band_valid),
        .band_stall  (band_stall),
        .band_item   (band_item),
        .pitch_valid (pitch_valid),
        .pitch_stall (pitch_stall),
        .pitch_item  (pitch_item),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    hsps_pitch_checker pitch_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .band_valid  (band_valid),
        .band_stall  (band_stall),
        .band_item   (band_item),
        .pitch_valid (pitch_valid),
        .pitch_stall (pitch_stall),
        .pitch_item  (pitch_item),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // hard stop; a correct run needs a small fraction of this
    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // one band transfer; random idle cycles go in front, decided without looking at stall,
    // and the payload stays put while the block stalls
    task automatic send_band(input logic [POWER_W-1:0] power, input logic last);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            band_valid <= 1'b0;
            @(posedge clk);
        end
        band_valid <= 1'b1;
        band_item  <= '{band_power: power, frame_end: last};
        @(posedge clk);
        while (band_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // valid is left high so back-to-back writes need no second assignment in one step
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BAND_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // new search range, written only once the block has gone idle
    task automatic set_range(input logic [BAND_W-1:0] lo, input logic [BAND_W-1:0] hi);
        band_valid <= 1'b0;
        // pending is registered in the checker, so look only after the next edge
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        // the result passes through the output register after the search; leave margin
        repeat (SETTLE_CYCLES) @(posedge clk);
        if ($urandom_range(0, 2) == 0)
            write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_2 : CFG_SPARE_3,
                      BAND_W'($urandom));
        write_reg(CFG_MIN_BAND, lo);
        write_reg(CFG_MAX_BAND, hi);
        cfg_valid <= 1'b0;
    endtask

    // one frame of random powers; a quarter of frames are sparse with one repeated level,
    // which makes equal scores on several roots likely
    task automatic send_random_frame(input int len);
        bit                 sparse;
        logic [POWER_W-1:0] power;
        int                 i;
        sparse = ($urandom_range(0, 3) == 0);
        for (i = 0; i < len; i++)
        begin
            if (sparse)
                power = ($urandom_range(0, 3) == 0) ? 32'h0001_0000 : '0;
            else
            begin
                case ($urandom_range(0, 7))
                    0:       power = '0;
                    1:       power = '1;
                    2:       power = POWER_W'($urandom_range(0, 255));
                    default: power = $urandom;
                endcase
            end
            send_band(power, i == len - 1);
        end
        frames_sent++;
    endtask

    // result side: random stalls, a calm stretch, and one long hold-off counted here so
    // that the output register fills and the block stalls band transfers
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                pitch_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            pitch_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    initial
    begin
        int                phase;
        int                rnd_frames;
        int                n;
        int                len;
        int                i;
        logic [BAND_W-1:0] lo;
        logic [BAND_W-1:0] hi;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames under the reset range
        // single full-scale band: largest possible one-tap score at root 0
        send_band('1, 1'b1);
        // all-zero frame: no positive score, so band 0 and score 0
        send_band('0, 1'b0);
        send_band('0, 1'b1);
        // equal peaks on roots 5 and 10: the lower root must win the tie
        for (i = 0; i < 11; i++)
            send_band((i == 5 || i == 10) ? 32'h0001_0000 : '0, i == 10);
        // alternating bit patterns toggle every power bit
        for (i = 0; i < 5; i++)
            send_band(i[0] ? 32'h5555_5555 : 32'hAAAA_AAAA, i == 4);

        // random frames in phases, each phase under its own search range
        phase      = 0;
        rnd_frames = 0;
        while (items_sent < ITEM_TARGET || frames_sent < FRAME_TARGET)
        begin
            case (phase)
                0:       begin lo = 8'd0;   hi = 8'd255; end  // widest range
                1:       begin lo = 8'd255; hi = 8'd255; end  // empty range at the top
                2:       begin lo = 8'd200; hi = 8'd37;  end  // reversed range
                3:       begin lo = 8'd0;   hi = 8'd0;   end  // empty range at the bottom
                4:       begin lo = 8'd0;   hi = 8'd172; end  // back to the reset range
                default:
                begin
                    if ($urandom_range(0, 7) == 0)
                    begin
                        lo = BAND_W'($urandom);
                        hi = BAND_W'($urandom);
                    end
                    else
                    begin
                        lo = BAND_W'($urandom_range(0, 200));
                        hi = BAND_W'($urandom_range(int'(lo), 255));
                    end
                end
            endcase
            set_range(lo, hi);

            n = $urandom_range(3, 6);
            repeat (n)
            begin
                calm = (rnd_frames >= 10 && rnd_frames < 16);
                if (rnd_frames == 3)
                    hold_req = 1'b1;
                // the first frame overruns the store, its frame-end band is dropped
                if (phase == 0 && rnd_frames == 0)
                    len = LONG_FRAME;
                else
                begin
                    case ($urandom_range(0, 9))
                        0:       len = $urandom_range(200, 270);
                        1, 2:    len = $urandom_range(40, 140);
                        default: len = $urandom_range(1, 40);
                    endcase
                end
                send_random_frame(len);
                rnd_frames++;
            end
            phase++;
        end
        calm = 1'b0;

        band_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
